FILE: sv/skit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skit_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int KEY_W = 64;
   localparam int ID_W  = 10;
   localparam int POS_W = 11;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;
   localparam int RPOS_W = 10;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_BOUND  = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_INS_CMP,
      S_INS_PUT,
      S_BS_STEP,
      S_BS_CMP,
      S_EX_CHK,
      S_RD_WAIT,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: sv/skit_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module skit_mem import skit_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data_ff
);

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/sorted_key_index_table.sv
`timescale 1ns / 1ps
`default_nettype none
// sorted table of signed 64-bit keys, descending, each with an entry id
// request channel (req_*): opcode, key, position; one word accepted at a time,
// req_ready is high only while the block is idle and out of reset
// response channel (rsp_*): status, entry_id, found_position, entry_key,
// exactly one response word per request word, in order
// all work goes through one single-port-read table memory (registered read)
// and one shared signed key comparator driven by a small sequencer
// insert: each smaller entry is shifted up one place, from the end of the
// table down, then the new entry is written at the freed place; a full
// table answers with the full status and no write
// exact search / bound: binary search over the entries, then for a search a
// final key check at the found place
// read at position: one table read; a position out of range answers with the
// range status and no read
// the next request can be taken in the cycle after the response word is taken
// reset empties the table (count to zero); entries need no clearing pass
// if the receiver stalls, the response word holds and no new request is taken

module sorted_key_index_table import skit_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [OP_W-1:0]         req_opcode,
   input  wire logic signed [KEY_W-1:0] req_key,
   input  wire logic [RPOS_W-1:0]       req_position,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [ST_W-1:0]              rsp_status,
   output logic [ID_W-1:0]              rsp_entry_id,
   output logic [POS_W-1:0]             rsp_found_position,
   output logic signed [KEY_W-1:0]      rsp_entry_key
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = (CW > RPOS_W) ? CW : RPOS_W;

   state_type state_ff, state_in;
   opcode_type op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [RPOS_W-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [ST_W-1:0] status_ff, status_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [POS_W-1:0] fpos_ff, fpos_in;
   logic signed [KEY_W-1:0] ekey_ff, ekey_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   entry_type wr_data;
   entry_type rd_data;

   logic rd_lt;
   logic rd_eq;
   logic [CW:0] mid_sum;
   logic [CW-1:0] mid;
   logic [CW-1:0] idx_dec;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] count_ext;

   skit_mem #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   // shared comparator: stored key against probe key
   assign rd_lt = rd_data.key < key_ff;
   assign rd_eq = rd_data.key == key_ff;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign idx_dec   = idx_ff - CW'(1);
   assign pos_ext   = PW'(pos_ff);
   assign count_ext = PW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      fpos_ff   <= fpos_in;
      ekey_ff   <= ekey_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      status_in = status_ff;
      id_in     = id_ff;
      fpos_in   = fpos_ff;
      ekey_in   = ekey_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_dec[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               key_in   = req_key;
               pos_in   = req_position;
               state_in = S_START;
            end
         end
         S_START: begin
            status_in = ST_OK;
            id_in     = '0;
            fpos_in   = '0;
            ekey_in   = '0;
            unique case (op_ff)
               OP_INSERT: begin
                  idx_in = count_ff;
                  if (count_ff == CW'(TABLE_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else if (count_ff == '0) begin
                     state_in = S_INS_PUT;
                  end else begin
                     rd_addr  = AW'(count_ff - CW'(1));
                     state_in = S_INS_CMP;
                  end
               end
               OP_SEARCH, OP_BOUND: begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = S_BS_STEP;
               end
               OP_READ: begin
                  if (pos_ext < count_ext) begin
                     rd_addr  = AW'(pos_ff);
                     state_in = S_RD_WAIT;
                  end else begin
                     status_in = ST_RANGE;
                     state_in  = S_RESP;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_INS_CMP: begin
            if (rd_lt) begin
               // shift the smaller entry up one place
               wr_en   = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = rd_data;
               idx_in  = idx_dec;
               if (idx_dec != '0) begin
                  rd_addr = AW'(idx_dec - CW'(1));
               end else begin
                  state_in = S_INS_PUT;
               end
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            wr_en       = 1'b1;
            wr_addr     = idx_ff[AW-1:0];
            wr_data.key = key_ff;
            wr_data.id  = ID_W'(count_ff);
            id_in       = ID_W'(count_ff);
            fpos_in     = POS_W'(idx_ff);
            count_in    = count_ff + CW'(1);
            state_in    = S_RESP;
         end
         S_BS_STEP: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[AW-1:0];
               mid_in   = mid;
               state_in = S_BS_CMP;
            end else if (op_ff == OP_BOUND) begin
               fpos_in  = POS_W'(lo_ff);
               state_in = S_RESP;
            end else if (lo_ff < count_ff) begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = S_EX_CHK;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_BS_CMP: begin
            if (!rd_lt && !rd_eq) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_BS_STEP;
         end
         S_EX_CHK: begin
            if (rd_eq) begin
               id_in = rd_data.id;
            end else begin
               status_in = ST_NOT_FOUND;
            end
            state_in = S_RESP;
         end
         S_RD_WAIT: begin
            id_in    = rd_data.id;
            ekey_in  = rd_data.key;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready          = !reset && (state_ff == S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = status_ff;
   assign rsp_entry_id       = id_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_entry_key      = ekey_ff;

endmodule

`default_nettype wire

FILE: sv/skit_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module skit_checker import skit_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [ST_W-1:0]         rsp_status,
   input wire logic [ID_W-1:0]         rsp_entry_id,
   input wire logic [POS_W-1:0]        rsp_found_position,
   input wire logic signed [KEY_W-1:0] rsp_entry_key
);

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one word in flight: never ready for a request while a response waits
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while response pending");

   // an accepted request drops ready at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after accept");

   // full table gives zero in the other fields
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_entry_id == '0 && rsp_found_position == '0 && rsp_entry_key == '0))
      else $error("nonzero fields with full status");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_id)
          && $stable(rsp_found_position) && $stable(rsp_entry_key)))
      else $error("response word changed while stalled");

endmodule

bind sorted_key_index_table skit_checker u_skit_checker (.*);

`default_nettype wire
